>>> src/assert_macros.svh
// Assertion macros for the RTL of the unit-sphere intersect block.
// Holds macros only; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define RUSI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rusi assertion failed");

// Condition that must never be seen on a clock edge out of reset.
`define RUSI_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `RUSI_ASSERT(lbl, clk, rstn, !(cond))

`endif

>>> src/rusi_pkg.sv
// Shared types and constants of the unit-sphere intersect block.
// No dependencies; used by every module of the block.
`default_nettype none

package rusi_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned FQ_DEPTH_DEF  = 4;

  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W = 6 * WORD_W;
  localparam int unsigned OUT_DATA_W = 3 * WORD_W;
  localparam int unsigned OUT_USER_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_LO = 3'd0,
    REG_ROW0_HI = 3'd1,
    REG_ROW1_LO = 3'd2,
    REG_ROW1_HI = 3'd3,
    REG_ROW2_LO = 3'd4,
    REG_ROW2_HI = 3'd5
  } cfg_reg_e;

  // Quadratic terms handed from the front to the back
  typedef struct packed {
    logic               noh;   // no crossing: zero direction or negative discriminant
    logic [127:0]       disc;  // discriminant h*h - a*c
    logic signed [65:0] nh;    // -h
    logic [63:0]        a;     // d'.d'
  } quad_t;

endpackage

`default_nettype wire

>>> src/rusi_fifo.sv
// Short queue of quadratic terms between the front and the back.
// Depends on rusi_pkg (quad_t).
`default_nettype none

module rusi_fifo #(
  parameter int unsigned DEPTH = rusi_pkg::FQ_DEPTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  rusi_pkg::quad_t     item_i,
  output logic                full_o,
  input  wire                 pop_i,
  output rusi_pkg::quad_t     item_o,
  output logic                empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rusi_pkg::quad_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/rusi_front.sv
// Front of the intersect block: holds the inverse transform, maps the ray into
// object space and forms the quadratic terms. Depends on rusi_pkg.
`default_nettype none

module rusi_front #(
  parameter int unsigned FRAC_BITS = rusi_pkg::FRAC_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire [rusi_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire [rusi_pkg::CFG_W-1:0]            cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire [rusi_pkg::IN_DATA_W-1:0]        in_data_i,
  input  wire                                  fq_full_i,
  output logic                                 fq_push_o,
  output rusi_pkg::quad_t                      fq_item_o
);

  localparam logic [63:0] ONE64  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] ONE_Q2 = 64'd1 << (2 * FRAC_BITS);
  localparam logic signed [65:0] MAXW = 66'sd2147483647;
  localparam logic signed [65:0] MINW = -66'sd2147483648;

  function automatic logic signed [63:0] mul_s(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    return x * y;
  endfunction

  function automatic logic [63:0] mul_u(input logic [31:0] x, input logic [31:0] y);
    return x * y;
  endfunction

  // floor shift by the fraction width, clipped to a signed word
  function automatic logic signed [31:0] sat_word(input logic signed [65:0] v);
    logic signed [65:0] sh;
    sh = v >>> FRAC_BITS;
    if (sh > MAXW) begin
      return 32'sh7fffffff;
    end else if (sh < MINW) begin
      return 32'sh80000000;
    end
    return sh[31:0];
  endfunction

  // Configuration registers
  logic [63:0] cfg_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= ONE64;
      cfg_q[1] <= '0;
      cfg_q[2] <= ONE64 << 32;
      cfg_q[3] <= '0;
      cfg_q[4] <= '0;
      cfg_q[5] <= ONE64;
    end else if (cfg_we_i) begin
      case (rusi_pkg::cfg_reg_e'(cfg_idx_i))
        rusi_pkg::REG_ROW0_LO: cfg_q[0] <= cfg_data_i;
        rusi_pkg::REG_ROW0_HI: cfg_q[1] <= cfg_data_i;
        rusi_pkg::REG_ROW1_LO: cfg_q[2] <= cfg_data_i;
        rusi_pkg::REG_ROW1_HI: cfg_q[3] <= cfg_data_i;
        rusi_pkg::REG_ROW2_LO: cfg_q[4] <= cfg_data_i;
        rusi_pkg::REG_ROW2_HI: cfg_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Matrix words and ray fields
  logic signed [31:0] m [3][3];
  logic signed [31:0] tr [3];
  logic signed [31:0] o [3];
  logic signed [31:0] d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[i][0] = cfg_q[2*i][31:0];
      m[i][1] = cfg_q[2*i][63:32];
      m[i][2] = cfg_q[2*i+1][31:0];
      tr[i]   = cfg_q[2*i+1][63:32];
      o[i]    = in_data_i[32*i +: 32];
      d[i]    = in_data_i[96 + 32*i +: 32];
    end
  end

  // Stage valids and advance
  logic [8:0] vld_q;
  logic       en;

  assign en         = !vld_q[8] || !fq_full_i;
  assign in_ready_o = en;
  assign fq_push_o  = vld_q[8] && !fq_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[7:0], in_valid_i};
    end
  end

  // Stage 1: matrix times origin and direction
  logic signed [63:0] po_q [3][3];
  logic signed [63:0] pd_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          po_q[i][j] <= mul_s(m[i][j], o[j]);
          pd_q[i][j] <= mul_s(m[i][j], d[j]);
        end
      end
    end
  end

  // Stage 2: row sums plus translation
  logic signed [65:0] so_q [3];
  logic signed [65:0] sd_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        so_q[i] <= (66'(tr[i]) <<< FRAC_BITS) + 66'(po_q[i][0]) + 66'(po_q[i][1])
                   + 66'(po_q[i][2]);
        sd_q[i] <= 66'(pd_q[i][0]) + 66'(pd_q[i][1]) + 66'(pd_q[i][2]);
      end
    end
  end

  // Stage 3: back to Q format, clipped
  logic signed [31:0] ot_q [3];
  logic signed [31:0] dt_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ot_q[i] <= sat_word(so_q[i]);
        dt_q[i] <= sat_word(sd_q[i]);
      end
    end
  end

  // Stage 4: component products for the dot products
  logic [63:0]        dd_q [3];
  logic [63:0]        oo_q [3];
  logic signed [63:0] dh_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd_q[i] <= mul_s(dt_q[i], dt_q[i]);
        oo_q[i] <= mul_s(ot_q[i], ot_q[i]);
        dh_q[i] <= mul_s(dt_q[i], ot_q[i]);
      end
    end
  end

  // Stage 5: dot products a, o'.o' and h
  logic [63:0]        a5_q, osq5_q;
  logic signed [65:0] h5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a5_q   <= dd_q[0] + dd_q[1] + dd_q[2];
      osq5_q <= oo_q[0] + oo_q[1] + oo_q[2];
      h5_q   <= 66'(dh_q[0]) + 66'(dh_q[1]) + 66'(dh_q[2]);
    end
  end

  // Stage 6: |h|, -h and |c| with the sign of c
  logic signed [65:0] nh6_d;
  logic [63:0]        hm6_q, k6_q, a6_q;
  logic signed [65:0] nh6_q;
  logic               lt6_q, az6_q;

  assign nh6_d = -h5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hm6_q <= h5_q[65] ? nh6_d[63:0] : h5_q[63:0];
      nh6_q <= nh6_d;
      lt6_q <= (osq5_q < ONE_Q2);
      k6_q  <= (osq5_q < ONE_Q2) ? (ONE_Q2 - osq5_q) : (osq5_q - ONE_Q2);
      a6_q  <= a5_q;
      az6_q <= (a5_q == '0);
    end
  end

  // Stage 7: 32-bit partial products of h*h and a*|c|
  logic [63:0]        hh00_q, hh01_q, hh11_q, ak00_q, ak01_q, ak10_q, ak11_q;
  logic [63:0]        a7_q;
  logic signed [65:0] nh7_q;
  logic               lt7_q, az7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hh00_q <= mul_u(hm6_q[31:0], hm6_q[31:0]);
      hh01_q <= mul_u(hm6_q[31:0], hm6_q[63:32]);
      hh11_q <= mul_u(hm6_q[63:32], hm6_q[63:32]);
      ak00_q <= mul_u(a6_q[31:0], k6_q[31:0]);
      ak01_q <= mul_u(a6_q[31:0], k6_q[63:32]);
      ak10_q <= mul_u(a6_q[63:32], k6_q[31:0]);
      ak11_q <= mul_u(a6_q[63:32], k6_q[63:32]);
      a7_q   <= a6_q;
      nh7_q  <= nh6_q;
      lt7_q  <= lt6_q;
      az7_q  <= az6_q;
    end
  end

  // Stage 8: assemble the 128-bit products
  logic [127:0]       h2_q, ac_q;
  logic [63:0]        a8_q;
  logic signed [65:0] nh8_q;
  logic               lt8_q, az8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h2_q  <= 128'(hh00_q) + (128'(hh01_q) << 33) + (128'(hh11_q) << 64);
      ac_q  <= 128'(ak00_q) + (128'(ak01_q) << 32) + (128'(ak10_q) << 32)
               + (128'(ak11_q) << 64);
      a8_q  <= a7_q;
      nh8_q <= nh7_q;
      lt8_q <= lt7_q;
      az8_q <= az7_q;
    end
  end

  // Stage 9: discriminant and the no-crossing decision
  logic [128:0]    diff9_d;
  rusi_pkg::quad_t item_q;

  assign diff9_d = {1'b0, h2_q} - {1'b0, ac_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      item_q.disc <= lt8_q ? (h2_q + ac_q) : diff9_d[127:0];
      item_q.noh  <= az8_q || (!lt8_q && diff9_d[128]);
      item_q.nh   <= nh8_q;
      item_q.a    <= a8_q;
    end
  end

  assign fq_item_o = item_q;

endmodule

`default_nettype wire

>>> src/rusi_back.sv
// Back of the intersect block: square root of the discriminant, the two root
// divisions, clipping and near-hit selection. Depends on rusi_pkg.
`default_nettype none

module rusi_back #(
  parameter int unsigned FRAC_BITS = rusi_pkg::FRAC_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                fq_empty_i,
  input  rusi_pkg::quad_t                    fq_item_i,
  output logic                               fq_pop_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [rusi_pkg::OUT_DATA_W-1:0]    out_data_o,
  output logic [rusi_pkg::OUT_USER_W-1:0]    out_user_o
);

  localparam int unsigned SQ_N  = 64;
  localparam int unsigned DV_N  = 33;
  localparam int unsigned NSTG  = SQ_N + 2 + DV_N + 1;
  localparam int unsigned SH    = 32 - FRAC_BITS;

  typedef struct packed {
    logic               noh;
    logic signed [65:0] nh;
    logic [63:0]        a;
  } side_t;

  // {sat, value}: quotient turned into a signed clipped root
  function automatic logic [32:0] finish(input logic ovf, input logic neg,
                                         input logic [31:0] q, input logic [63:0] rem);
    logic [32:0] qq;
    logic [32:0] nq;
    qq = {1'b0, q} + {32'b0, (rem != '0)};
    nq = ~qq + 33'd1;
    if (neg) begin
      if (ovf || (qq > 33'h080000000)) begin
        return {1'b1, 32'h80000000};
      end
      return {1'b0, nq[31:0]};
    end
    if (ovf || q[31]) begin
      return {1'b1, 32'h7fffffff};
    end
    return {1'b0, q};
  endfunction

  // Advance and valid chain
  logic [NSTG-1:0] vld_q;
  logic            en;

  assign en          = !vld_q[NSTG-1] || out_ready_i;
  assign fq_pop_o    = en && !fq_empty_i;
  assign out_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], !fq_empty_i};
    end
  end

  // Square root: one result bit per stage
  logic [65:0]  sq_rem_q  [SQ_N];
  logic [63:0]  sq_root_q [SQ_N];
  logic [127:0] sq_rad_q  [SQ_N];
  side_t        sq_side_q [SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    logic [65:0]  rem_in;
    logic [63:0]  root_in;
    logic [127:0] rad_in;
    side_t        side_in;
    logic [67:0]  trial_v;
    logic [67:0]  t_v;
    logic [68:0]  diff_v;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = fq_item_i.disc;
      assign side_in = '{noh: fq_item_i.noh, nh: fq_item_i.nh, a: fq_item_i.a};
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign rad_in  = sq_rad_q[k-1];
      assign side_in = sq_side_q[k-1];
    end

    assign t_v     = {rem_in, rad_in[127:126]};
    assign trial_v = {2'b00, root_in, 2'b01};
    assign diff_v  = {1'b0, t_v} - {1'b0, trial_v};

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k]  <= diff_v[68] ? t_v[65:0] : diff_v[65:0];
        sq_root_q[k] <= {root_in[62:0], !diff_v[68]};
        sq_rad_q[k]  <= {rad_in[125:0], 2'b00};
        sq_side_q[k] <= side_in;
      end
    end
  end

  // Root numerators -h -+ s; the root enters as a signed 64-bit word
  logic signed [66:0] n_q [2];
  logic [63:0]        p1_a_q;
  logic               p1_noh_q;
  logic signed [66:0] nh_ext;
  logic signed [66:0] s_ext;

  assign nh_ext = 67'(sq_side_q[SQ_N-1].nh);
  assign s_ext  = 67'($signed(sq_root_q[SQ_N-1]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q[0]   <= nh_ext - s_ext;
      n_q[1]   <= nh_ext + s_ext;
      p1_a_q   <= sq_side_q[SQ_N-1].a;
      p1_noh_q <= sq_side_q[SQ_N-1].noh;
    end
  end

  // Sign and low 64 bits of the magnitude
  logic               p2_neg_q [2];
  logic [63:0]        p2_mag_q [2];
  logic [63:0]        p2_a_q;
  logic               p2_noh_q;
  logic signed [66:0] nn [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nn[l] = -n_q[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        p2_neg_q[l] <= n_q[l][66];
        p2_mag_q[l] <= n_q[l][66] ? nn[l][63:0] : n_q[l][63:0];
      end
      p2_a_q   <= p1_a_q;
      p2_noh_q <= p1_noh_q;
    end
  end

  // Division (mag << FRAC_BITS) / a: overflow check, then one bit per stage
  logic [63:0] dv_a_q   [DV_N];
  logic        dv_noh_q [DV_N];
  logic [63:0] dv_rem_q [2][DV_N];
  logic [31:0] dv_q_q   [2][DV_N];
  logic [31:0] dv_low_q [2][DV_N];
  logic        dv_ovf_q [2][DV_N];
  logic        dv_neg_q [2][DV_N];

  for (genvar j = 0; j < DV_N; j++) begin : g_dv
    if (j == 0) begin : g_init
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_a_q[0]   <= p2_a_q;
          dv_noh_q[0] <= p2_noh_q;
        end
      end
    end else begin : g_step
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_a_q[j]   <= dv_a_q[j-1];
          dv_noh_q[j] <= dv_noh_q[j-1];
        end
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      if (j == 0) begin : g_init
        always_ff @(posedge clk_i) begin
          if (en) begin
            dv_ovf_q[l][0] <= ({{SH{1'b0}}, p2_mag_q[l]} >= {p2_a_q, {SH{1'b0}}});
            dv_rem_q[l][0] <= p2_mag_q[l] >> SH;
            dv_low_q[l][0] <= {p2_mag_q[l][SH-1:0], {FRAC_BITS{1'b0}}};
            dv_q_q[l][0]   <= '0;
            dv_neg_q[l][0] <= p2_neg_q[l];
          end
        end
      end else begin : g_step
        logic [64:0] t_v;
        logic [65:0] diff_v;

        assign t_v    = {dv_rem_q[l][j-1], dv_low_q[l][j-1][31]};
        assign diff_v = {1'b0, t_v} - {2'b00, dv_a_q[j-1]};

        always_ff @(posedge clk_i) begin
          if (en) begin
            dv_rem_q[l][j] <= diff_v[65] ? t_v[63:0] : diff_v[63:0];
            dv_q_q[l][j]   <= {dv_q_q[l][j-1][30:0], !diff_v[65]};
            dv_low_q[l][j] <= {dv_low_q[l][j-1][30:0], 1'b0};
            dv_ovf_q[l][j] <= dv_ovf_q[l][j-1];
            dv_neg_q[l][j] <= dv_neg_q[l][j-1];
          end
        end
      end
    end
  end

  // Output register: clipped roots and the nearest root in front
  logic [32:0]                       r0, r1;
  logic [31:0]                       ft;
  logic                              fv;
  logic [rusi_pkg::OUT_DATA_W-1:0]   out_data_q;
  logic [rusi_pkg::OUT_USER_W-1:0]   out_user_q;

  always_comb begin
    r0 = finish(dv_ovf_q[0][DV_N-1], dv_neg_q[0][DV_N-1], dv_q_q[0][DV_N-1],
                dv_rem_q[0][DV_N-1]);
    r1 = finish(dv_ovf_q[1][DV_N-1], dv_neg_q[1][DV_N-1], dv_q_q[1][DV_N-1],
                dv_rem_q[1][DV_N-1]);
    fv = 1'b1;
    ft = '0;
    if (!r0[31]) begin
      ft = r0[31:0];
    end else if (!r1[31]) begin
      ft = r1[31:0];
    end else begin
      fv = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dv_noh_q[DV_N-1]) begin
        out_data_q <= '0;
        out_user_q <= '0;
      end else begin
        out_data_q <= {ft, r1[31:0], r0[31:0]};
        out_user_q <= {r0[32] || r1[32], fv, 1'b1};
      end
    end
  end

  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

endmodule

`default_nettype wire

>>> src/ray_unit_sphere_intersect.sv
// Top level of the ray against unit sphere intersect block.
// Depends on rusi_pkg, rusi_front, rusi_fifo, rusi_back and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// Takes one ray word per cycle and gives one result word per ray, in order.
// Rays are fully pipelined: a new ray is accepted every cycle while the output
// side keeps taking results. A ray passes through the front (transform and
// quadratic terms), the queue, then the back, chiefly the 64-stage square root
// (one root bit a stage) and the root dividers (one quotient bit a stage). The
// user must write the inverse transform registers only while no ray is in
// flight; the block itself does not enforce it. They reset to the identity.
module ray_unit_sphere_intersect #(
  parameter int unsigned FRAC_BITS = rusi_pkg::FRAC_BITS_DEF,
  parameter int unsigned FQ_DEPTH  = rusi_pkg::FQ_DEPTH_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration write port
  input  wire                                 cfg_we_i,
  input  wire [rusi_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire [rusi_pkg::CFG_W-1:0]           cfg_data_i,
  // ray input
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  wire [rusi_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // result output
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // t_near, t_far, front_t
  output logic [rusi_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // crosses, front_valid, saturated
  output logic [rusi_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

  logic            fq_push, fq_full, fq_pop, fq_empty;
  rusi_pkg::quad_t fq_wr_item, fq_rd_item;

  rusi_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .fq_full_i  (fq_full),
    .fq_push_o  (fq_push),
    .fq_item_o  (fq_wr_item)
  );

  rusi_fifo #(
    .DEPTH (FQ_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .item_i  (fq_wr_item),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .item_o  (fq_rd_item),
    .empty_o (fq_empty)
  );

  rusi_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fq_empty_i  (fq_empty),
    .fq_item_i   (fq_rd_item),
    .fq_pop_o    (fq_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  // queue never overrun or underrun
  `RUSI_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, fq_push && fq_full)
  `RUSI_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, fq_pop && fq_empty)
  // a miss carries an all-zero word
  `RUSI_ASSERT(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0) && (m_axis_tuser == '0))
  // a front hit is never behind the origin
  `RUSI_ASSERT(a_front_nonneg, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tdata[95])

endmodule

`default_nettype wire
